// ----- hdl/mexp_pkg.sv -----
// Shared constants and types for the modular exponentiation unit.
// No dependencies; every other file in hdl/ imports this package.
package mexp_pkg;

  // Default internal word width. Operands are taken in their low bits at this width.
  localparam int DEF_WORD_WIDTH = 32;

  // Fixed width of the base, result and configuration data ports.
  localparam int FIELD_W = 32;

  // Configuration register index width and register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [FIELD_W-1:0] MODULUS_RESET  = 32'd1;
  localparam logic [FIELD_W-1:0] EXPONENT_RESET = 32'd1;

  typedef logic [FIELD_W-1:0]     field_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

endpackage

// ----- hdl/mexp_modmul.sv -----
// Bit-serial modular multiplier: p = a * b mod m, one bit of b per cycle.
// Depends on mexp_pkg for the default word width.
module mexp_modmul
  import mexp_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] b,
  input  logic [WORD_WIDTH-1:0] m,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] p
);

  localparam int CW = $clog2(WORD_WIDTH);
  localparam int SW = WORD_WIDTH + 2;

  logic                  run;
  logic [CW-1:0]         cnt;
  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] a_reg;
  logic [WORD_WIDTH-1:0] b_sh;
  logic [WORD_WIDTH-1:0] acc_next;
  logic [WORD_WIDTH-1:0] addend;
  logic [SW-1:0]         sum;
  logic [SW-1:0]         m1;
  logic [SW-1:0]         m2;

  // One step: acc = (2*acc + bit*a) mod m, with acc < m and a < m, so the sum is below 3m.
  always_comb begin
    addend = b_sh[WORD_WIDTH-1] ? a_reg : '0;
    sum    = {1'b0, acc, 1'b0} + {2'b00, addend};
    m1     = {2'b00, m};
    m2     = {1'b0, m, 1'b0};
    if (sum >= m2) begin
      acc_next = WORD_WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = WORD_WIDTH'(sum - m1);
    end else begin
      acc_next = WORD_WIDTH'(sum);
    end
  end

  // Control: a load starts a run of WORD_WIDTH steps, done pulses after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
        cnt <= CW'(WORD_WIDTH - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: the multiplier operand shifts out most significant bit first.
  always_ff @(posedge clk) begin
    if (load) begin
      acc   <= '0;
      a_reg <= a;
      b_sh  <= b;
    end else if (run) begin
      acc  <= acc_next;
      b_sh <= {b_sh[WORD_WIDTH-2:0], 1'b0};
    end
  end

  assign p = acc;

endmodule

// ----- hdl/mexp_seq.sv -----
// Square-and-multiply sequencer: reduces the base, then walks the exponent bits
// from the top, issuing squarings and multiplications to mexp_modmul. Uses mexp_pkg.
module mexp_seq
  import mexp_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [WORD_WIDTH-1:0] m_in,
  input  logic [WORD_WIDTH-1:0] e_in,
  input  logic [WORD_WIDTH-1:0] base_in,
  input  logic                  mm_done,
  input  logic [WORD_WIDTH-1:0] mm_p,
  output logic                  mm_load,
  output logic [WORD_WIDTH-1:0] mm_a,
  output logic [WORD_WIDTH-1:0] mm_b,
  output logic [WORD_WIDTH-1:0] mod_w,
  output logic                  active,
  output logic                  fin,
  output logic [WORD_WIDTH-1:0] res
);

  localparam int CW = $clog2(WORD_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_SQR  = 2'd2;
  localparam logic [1:0] S_MUL  = 2'd3;

  logic [1:0]            state;
  logic [CW-1:0]         pos;
  logic [WORD_WIDTH-1:0] exp_sh;
  logic [WORD_WIDTH-1:0] base_red;
  logic [WORD_WIDTH-1:0] acc;
  logic                  last_bit;

  assign last_bit = (pos == '0);
  assign active   = (state != S_IDLE);

  // Control state: out of idle, steps only when the multiplier reports a product.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mm_load <= 1'b0;
      fin     <= 1'b0;
    end else begin
      mm_load <= 1'b0;
      fin     <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go) begin
            if (m_in == '0) begin
              fin <= 1'b1;
            end else begin
              mm_load <= 1'b1;
              state   <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mm_done) begin
            mm_load <= 1'b1;
            state   <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_done) begin
            if (exp_sh[WORD_WIDTH-1]) begin
              mm_load <= 1'b1;
              state   <= S_MUL;
            end else if (last_bit) begin
              fin   <= 1'b1;
              state <= S_IDLE;
            end else begin
              mm_load <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if (mm_done) begin
            if (last_bit) begin
              fin   <= 1'b1;
              state <= S_IDLE;
            end else begin
              mm_load <= 1'b1;
              state   <= S_SQR;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: operands for the next product, the exponent shifter and the final value.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (go) begin
          mod_w  <= m_in;
          exp_sh <= e_in;
          if (m_in == '0) begin
            res <= '0;
          end else begin
            // The base is reduced as (1 mod m) * base, with 1 mod m being 0 when m is one.
            acc  <= (m_in == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
            mm_a <= (m_in == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
            mm_b <= base_in;
          end
        end
      end
      S_RED: begin
        if (mm_done) begin
          base_red <= mm_p;
          mm_a     <= acc;
          mm_b     <= acc;
          pos      <= CW'(WORD_WIDTH - 1);
        end
      end
      S_SQR: begin
        if (mm_done) begin
          acc <= mm_p;
          if (exp_sh[WORD_WIDTH-1]) begin
            mm_a <= mm_p;
            mm_b <= base_red;
          end else begin
            exp_sh <= {exp_sh[WORD_WIDTH-2:0], 1'b0};
            mm_a   <= mm_p;
            mm_b   <= mm_p;
            res    <= mm_p;
            pos    <= pos - 1'b1;
          end
        end
      end
      S_MUL: begin
        if (mm_done) begin
          acc    <= mm_p;
          exp_sh <= {exp_sh[WORD_WIDTH-2:0], 1'b0};
          mm_a   <= mm_p;
          mm_b   <= mm_p;
          res    <= mm_p;
          pos    <= pos - 1'b1;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

// ----- hdl/modular_exponentiation_unit.sv -----
// Modular exponentiation unit: result = base ^ exponent mod modulus.
// Depends on mexp_pkg, mexp_modmul and mexp_seq.
//
// Usage:
//   Configuration: modulus (index 0) and exponent (index 1) are written through
//   cfg_valid / cfg_ready / cfg_index / cfg_data; a transfer happens when valid and
//   ready are both high. cfg_ready is always high. Writes to other indexes are dropped.
//   Write configuration only while busy is low and no result is pending.
//   Command: a transfer of base happens on a clock edge with start high and busy low.
//   The result appears on result, marked by done. The receiver
//   cannot stall; done is a single-cycle strobe.
// Timing:
//   One bit-serial modular multiplier does all the work at one bit per cycle. An item
//   needs one base reduction, WORD_WIDTH squarings and one multiplication per set
//   exponent bit. A zero modulus gives 0 in the cycle after the command transfer.
//   One item is in work at a time; busy drops as done is shown, so the next command
//   can be taken in the cycle that carries the result.
// Reset: rst is synchronous, active high; modulus and exponent return to 1, the unit idles.
module modular_exponentiation_unit
  import mexp_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  field_t     base,
  output logic       done,
  output field_t     result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  field_t     cfg_data
);

  field_t                modulus;
  field_t                exponent;
  logic                  go;
  logic                  mm_load;
  logic                  mm_done;
  logic [WORD_WIDTH-1:0] mm_a;
  logic [WORD_WIDTH-1:0] mm_b;
  logic [WORD_WIDTH-1:0] mm_p;
  logic [WORD_WIDTH-1:0] mod_w;
  logic [WORD_WIDTH-1:0] res_w;

  assign cfg_ready = 1'b1;
  assign go        = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= MODULUS_RESET;
      exponent <= EXPONENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:  modulus  <= cfg_data;
        REG_EXPONENT: exponent <= cfg_data;
        default:      modulus  <= modulus;
      endcase
    end
  end

  mexp_seq #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .m_in    (WORD_WIDTH'(modulus)),
    .e_in    (WORD_WIDTH'(exponent)),
    .base_in (WORD_WIDTH'(base)),
    .mm_done (mm_done),
    .mm_p    (mm_p),
    .mm_load (mm_load),
    .mm_a    (mm_a),
    .mm_b    (mm_b),
    .mod_w   (mod_w),
    .active  (busy),
    .fin     (done),
    .res     (res_w)
  );

  mexp_modmul #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_modmul (
    .clk  (clk),
    .rst  (rst),
    .load (mm_load),
    .a    (mm_a),
    .b    (mm_b),
    .m    (mod_w),
    .done (mm_done),
    .p    (mm_p)
  );

  assign result = FIELD_W'(res_w);

  // A result is only shown once the sequencer has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done asserted while busy");

  // An accepted command either starts work or completes at once.
  a_start_effect: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command had no effect");

  // A result follows either work in progress or a command transfer.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a command");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for modular_exponentiation_unit: base ^ exponent mod modulus.
// Depends on mexp_pkg and the RTL in hdl/. A directed table runs first, then random
// phases of configuration and bases, checked against given or in-line predicted powers.
module testbench;
  import mexp_pkg::*;

  // Cycles with no transfer of any kind before the run is declared hung.
  localparam int STALL_LIMIT = 20000;
  // Quiet cycles after the last result, to catch a stray strobe.
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS = 30;
  localparam int PHASE_COUNT = 9;

  // Register indexes with no register behind them; writes there are dropped.
  localparam cfg_index_t REG_SPARE_LO = REG_EXPONENT + 1'b1;
  localparam cfg_index_t REG_SPARE_HI = '1;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    cfg_index_t index;
    field_t     value;
    bit         typed;
    field_t     want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  field_t     base;
  logic       done;
  field_t     result;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  field_t     cfg_data;

  // Copy of the configuration as the unit should hold it.
  field_t modulus_copy;
  field_t exponent_copy;

  field_t    pending_results[$];
  stim_row_t stim_rows[$];
  int        mismatch_count;
  int        quiet_cycles;

  modular_exponentiation_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .base      (base),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 20-unit period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Left-to-right square-and-multiply over the exponent bits; a zero modulus gives 0.
  function automatic field_t mod_power(field_t b, field_t e, field_t m);
    logic [63:0] acc;
    logic [63:0] red_base;
    logic [63:0] m_wide;
    int k;
    if (m == '0) begin
      return '0;
    end
    m_wide = {32'd0, m};
    red_base = {32'd0, b} % m_wide;
    acc = 64'd1 % m_wide;
    for (k = DEF_WORD_WIDTH - 1; k >= 0; k--) begin
      acc = (acc * acc) % m_wide;
      if (e[k]) begin
        acc = (acc * red_base) % m_wide;
      end
    end
    return acc[FIELD_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input field_t got, input field_t want);
    $display("MISMATCH at %0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare every strobed result with the oldest expected power.
  always @(posedge clk) begin
    field_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", result, '0);
      end else begin
        want = pending_results.pop_front();
        if (result !== want) begin
          flag_mismatch("result", result, want);
        end
      end
    end
  end

  // Hang detection: count cycles in which no transfer of any kind happens.
  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one base and wait for its transfer; the expected power is queued on transfer.
  task automatic send_base(input field_t b, input bit typed, input field_t typed_want);
    start <= 1'b1;
    base <= b;
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    do @(posedge clk); while (busy !== 1'b0);
    if (typed) begin
      pending_results.push_back(typed_want);
    end else begin
      pending_results.push_back(mod_power(b, exponent_copy, modulus_copy));
    end
  endtask

  // Write one register once the unit is idle and every result has arrived.
  task automatic write_reg(input cfg_index_t idx, input field_t data);
    if (start) begin
      start <= 1'b0;
    end
    while (pending_results.size() != 0 || busy !== 1'b0) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_MODULUS: begin
        modulus_copy = data;
      end
      REG_EXPONENT: begin
        exponent_copy = data;
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_write(input cfg_index_t idx, input field_t data);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.index = idx;
    row.value = data;
    row.typed = 1'b0;
    row.want = '0;
    stim_rows.push_back(row);
  endtask

  task automatic add_item(input field_t b, input bit typed, input field_t want);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.index = REG_MODULUS;
    row.value = b;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  // Pick a base that often sits on the edges of the current modulus.
  function automatic field_t pick_base(field_t m);
    case ($urandom_range(9, 0))
      0: return '0;
      1: return 32'd1;
      2: return m - 1'b1;
      3: return m;
      4: return '1;
      5: return field_t'($urandom_range(15, 0));
      default: return field_t'($urandom);
    endcase
  endfunction

  // Pick the configuration of one random phase; the first phases hit the extremes.
  task automatic pick_setting(input int phase, output field_t m, output field_t e);
    case (phase)
      0: begin
        m = '1;
        e = '1;
      end
      1: begin
        m = field_t'($urandom) | 32'h8000_0001;
        e = 32'd65537;
      end
      2: begin
        m = 32'd1;
        e = field_t'($urandom);
      end
      3: begin
        m = '0;
        e = field_t'($urandom);
      end
      4: begin
        m = field_t'($urandom) | 32'd2;
        e = '0;
      end
      5: begin
        m = field_t'($urandom_range(16, 2));
        e = field_t'($urandom);
      end
      7: begin
        m = 32'h8000_0000;
        e = field_t'($urandom);
      end
      default: begin
        m = field_t'($urandom);
        e = field_t'($urandom);
      end
    endcase
  endtask

  // Main stimulus: reset, directed table, random phases, then drain and verdict.
  initial begin
    field_t m;
    field_t e;
    int burst_left;
    int gap;
    int phase;
    int n;

    rst <= 1'b1;
    start <= 1'b0;
    base <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MODULUS;
    cfg_data <= '0;
    modulus_copy = MODULUS_RESET;
    exponent_copy = EXPONENT_RESET;
    mismatch_count = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: reset values, zero and unit modulus, zero exponent,
    // bases at and above the modulus, dropped indexes and full-width operands.
    add_item('1, 1'b1, '0);
    add_item(32'd12345, 1'b1, '0);
    add_write(REG_MODULUS, '0);
    add_item(32'd12345, 1'b1, '0);
    add_write(REG_MODULUS, 32'd13);
    add_write(REG_EXPONENT, '0);
    add_item(32'd7, 1'b1, 32'd1);
    add_item('0, 1'b1, 32'd1);
    add_item(32'd13, 1'b1, 32'd1);
    add_write(REG_EXPONENT, 32'd1);
    add_item(32'd13, 1'b1, '0);
    add_item(32'd14, 1'b1, 32'd1);
    add_item(32'd12, 1'b1, 32'd12);
    add_write(REG_SPARE_LO, 32'd5);
    add_write(REG_SPARE_HI, '0);
    add_item(32'd3, 1'b1, 32'd3);
    add_write(REG_MODULUS, '1);
    add_write(REG_EXPONENT, '1);
    add_item('0, 1'b1, '0);
    add_item(32'd1, 1'b1, 32'd1);
    add_item('1, 1'b1, '0);
    add_item(32'hFFFF_FFFE, 1'b0, '0);
    add_item(32'h8000_0000, 1'b0, '0);
    add_write(REG_EXPONENT, 32'd2);
    add_item(32'hFFFF_FFFE, 1'b1, 32'd1);
    add_item(32'hDEAD_BEEF, 1'b0, '0);
    add_write(REG_MODULUS, 32'd1);
    add_item('1, 1'b1, '0);
    add_write(REG_MODULUS, 32'd2);
    add_write(REG_EXPONENT, 32'h8000_0000);
    add_item(32'd3, 1'b1, 32'd1);
    add_item(32'd2, 1'b1, '0);
    add_write(REG_MODULUS, 32'hFFFF_FFFB);
    add_write(REG_EXPONENT, 32'd65537);
    add_item(32'h1234_5678, 1'b0, '0);
    add_item(32'hFFFF_FFFC, 1'b0, '0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        write_reg(stim_rows[i].index, stim_rows[i].value);
      end else begin
        send_base(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random phases: new configuration in random order, then bursts of bases.
    burst_left = 0;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      pick_setting(phase, m, e);
      if ($urandom_range(1, 0) == 1) begin
        write_reg(cfg_index_t'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                  field_t'($urandom));
      end
      if ($urandom_range(1, 0) == 1) begin
        write_reg(REG_MODULUS, m);
        write_reg(REG_EXPONENT, e);
      end else begin
        write_reg(REG_EXPONENT, e);
        write_reg(REG_MODULUS, m);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          if (start) begin
            start <= 1'b0;
          end
          // The gap carries no configuration transfer either.
          if (cfg_valid) begin
            cfg_valid <= 1'b0;
          end
          if ($urandom_range(7, 0) == 0) begin
            gap = $urandom_range(2400, 40);
          end else begin
            gap = $urandom_range(6, 1);
          end
          repeat (gap) @(posedge clk);
          burst_left = ($urandom_range(4, 0) == 0) ? 30 : $urandom_range(8, 1);
        end
        send_base(pick_base(modulus_copy), 1'b0, '0);
        burst_left--;
      end
    end

    // Drain: wait for every expected result, then watch for stray strobes.
    start <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- modular_exponentiation_unit.f -----
hdl/mexp_pkg.sv
hdl/mexp_modmul.sv
hdl/mexp_seq.sv
hdl/modular_exponentiation_unit.sv
tb/testbench.sv
